[rtl/cell_neighbor_stencil_generator_assert.svh]
// Assertion macros shared by the stencil generator RTL.
`ifndef CELL_NEIGHBOR_STENCIL_GENERATOR_ASSERT_SVH
`define CELL_NEIGHBOR_STENCIL_GENERATOR_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define CNSG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define CNSG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/cnsg_pkg.sv]
// Types and constants of the cell neighbor stencil generator.
`timescale 1ns / 1ps

package cnsg_pkg;

	localparam int unsigned DIM_W   = 7;
	localparam int unsigned CRD_W   = 6;
	localparam int unsigned IDX_W   = 18;
	localparam int unsigned SLOT_W  = 5;
	localparam int unsigned FACE_W  = 3;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 32;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_GRID_X = 2'd0;
	localparam logic [1:0] REG_GRID_Y = 2'd1;
	localparam logic [1:0] REG_GRID_Z = 2'd2;

	// Offset codes along one axis: -1, 0, +1.
	localparam logic [1:0] OFS_NEG  = 2'd0;
	localparam logic [1:0] OFS_ZERO = 2'd1;
	localparam logic [1:0] OFS_POS  = 2'd2;

	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd4;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;
	localparam logic [FACE_W-1:0] FACE_NONE  = 3'd6;

	localparam logic [SLOT_W-1:0] SLOT_SELF = 5'd13;

	// Per-result tags that travel down the pipeline beside the index math.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              is_self;
		logic              in_half;
		logic [FACE_W-1:0] face;
		logic              oor;
		logic              last;
	} meta_t;

endpackage

[rtl/cell_neighbor_stencil_generator.sv]
// Top level of the cell neighbor stencil generator: point sequencer and index pipeline.
`timescale 1ns / 1ps

// Takes a target cell (x,y,z) and emits one transfer for each of its stencil neighbors
// that lies inside the configured grid, walking dx outermost, then dy, then dz, each from
// -1 to +1. A point sequencer issues one neighbor per cycle unless the output stalls it,
// so an item gives one transfer per in-grid neighbor: 27 for an interior cell, fewer at
// grid edges, and for a cell outside the grid a single error transfer. The sequencer takes
// the next cell in the cycle its last neighbor leaves, so items run back to back. Each
// neighbor then passes a three-stage pipeline (offset decode, the two products of the
// flattened index, final sum into the output register). Grid sizes above MAX_CELLS_PER_AXIS
// saturate to it, and size registers may be written only while the block is idle.
`include "cell_neighbor_stencil_generator_assert.svh"

module cell_neighbor_stencil_generator
	import cnsg_pkg::*;
#(
	parameter int unsigned MAX_CELLS_PER_AXIS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [DIM_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// Low bit up: cell_x[5:0], cell_y[5:0], cell_z[5:0], zero pad[5:0].
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// Low bit up: neighbor_index[17:0], stencil_slot[4:0], is_self, in_half_shell,
	// face_direction[2:0], zero pad[3:0].
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// out_of_range.
	output logic                   m_axis_tuser,
	// last_of_run.
	output logic                   m_axis_tlast
);

	localparam int unsigned MAX_CAP = (MAX_CELLS_PER_AXIS > 127) ? 127 : MAX_CELLS_PER_AXIS;
	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_CAP);

	// Configuration registers and effective sizes.
	logic [DIM_W-1:0] grid_x_q, grid_y_q, grid_z_q;
	logic [DIM_W-1:0] nx, ny, nz;
	logic [2*DIM_W-1:0] nxy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= DIM_W'(4);
			grid_y_q <= DIM_W'(4);
			grid_z_q <= DIM_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GRID_X: grid_x_q <= cfg_wdata;
				REG_GRID_Y: grid_y_q <= cfg_wdata;
				REG_GRID_Z: grid_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign nx = (grid_x_q > MAX_DIM) ? MAX_DIM : grid_x_q;
	assign ny = (grid_y_q > MAX_DIM) ? MAX_DIM : grid_y_q;
	assign nz = (grid_z_q > MAX_DIM) ? MAX_DIM : grid_z_q;

	always_ff @(posedge clk) begin
		nxy_q <= nx * ny;
	end

	// Stage enables: a stage moves when it is empty or the one after it moves.
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3 = !v_s3 || m_axis_tready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	// Point sequencer.
	logic             busy_q, err_q;
	logic [CRD_W-1:0] cx_q, cy_q, cz_q;
	logic [1:0]       dx_q, dy_q, dz_q;
	logic [1:0]       lox_q, loy_q, loz_q, hix_q, hiy_q, hiz_q;
	logic             seq_last, issue, accept;
	logic [CRD_W-1:0] in_x, in_y, in_z;
	logic [DIM_W-1:0] ex, ey, ez;
	logic             in_err;

	assign in_x = s_axis_tdata[CRD_W-1:0];
	assign in_y = s_axis_tdata[2*CRD_W-1:CRD_W];
	assign in_z = s_axis_tdata[3*CRD_W-1:2*CRD_W];
	assign ex   = {1'b0, in_x};
	assign ey   = {1'b0, in_y};
	assign ez   = {1'b0, in_z};
	assign in_err = (ex >= nx) || (ey >= ny) || (ez >= nz);

	assign seq_last = err_q || (dx_q == hix_q && dy_q == hiy_q && dz_q == hiz_q);
	assign issue    = busy_q && en1;
	assign s_axis_tready = !busy_q || (seq_last && en1);
	assign accept   = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (issue && seq_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q  <= in_x;
			cy_q  <= in_y;
			cz_q  <= in_z;
			err_q <= in_err;
			lox_q <= (in_x != '0) ? OFS_NEG : OFS_ZERO;
			loy_q <= (in_y != '0) ? OFS_NEG : OFS_ZERO;
			loz_q <= (in_z != '0) ? OFS_NEG : OFS_ZERO;
			hix_q <= ((ex + DIM_W'(1)) < nx) ? OFS_POS : OFS_ZERO;
			hiy_q <= ((ey + DIM_W'(1)) < ny) ? OFS_POS : OFS_ZERO;
			hiz_q <= ((ez + DIM_W'(1)) < nz) ? OFS_POS : OFS_ZERO;
			dx_q  <= (in_x != '0) ? OFS_NEG : OFS_ZERO;
			dy_q  <= (in_y != '0) ? OFS_NEG : OFS_ZERO;
			dz_q  <= (in_z != '0) ? OFS_NEG : OFS_ZERO;
		end else if (issue && !seq_last) begin
			if (dz_q != hiz_q) begin
				dz_q <= dz_q + 2'd1;
			end else begin
				dz_q <= loz_q;
				if (dy_q != hiy_q) begin
					dy_q <= dy_q + 2'd1;
				end else begin
					dy_q <= loy_q;
					dx_q <= dx_q + 2'd1;
				end
			end
		end
	end

	// Stage 1: neighbor coordinates and tags.
	logic [DIM_W-1:0] px_s1, py_s1, pz_s1;
	meta_t            meta_s1;
	meta_t            meta_nxt;
	logic             self_nxt;

	always_comb begin
		self_nxt = (dx_q == OFS_ZERO) && (dy_q == OFS_ZERO) && (dz_q == OFS_ZERO);
		meta_nxt.slot    = {3'b000, dx_q} * SLOT_W'(9) + {3'b000, dy_q} * SLOT_W'(3)
		                 + {3'b000, dz_q};
		meta_nxt.is_self = self_nxt;
		meta_nxt.in_half = !self_nxt &&
			((dy_q == OFS_ZERO && dz_q != OFS_NEG && dx_q != OFS_POS) ||
			 (dy_q == OFS_ZERO && dz_q == OFS_POS && dx_q == OFS_POS) ||
			 (dy_q == OFS_POS));
		if (dx_q != OFS_ZERO && dy_q == OFS_ZERO && dz_q == OFS_ZERO) begin
			meta_nxt.face = (dx_q == OFS_NEG) ? FACE_NEG_X : FACE_POS_X;
		end else if (dy_q != OFS_ZERO && dx_q == OFS_ZERO && dz_q == OFS_ZERO) begin
			meta_nxt.face = (dy_q == OFS_NEG) ? FACE_NEG_Y : FACE_POS_Y;
		end else if (dz_q != OFS_ZERO && dx_q == OFS_ZERO && dy_q == OFS_ZERO) begin
			meta_nxt.face = (dz_q == OFS_NEG) ? FACE_NEG_Z : FACE_POS_Z;
		end else begin
			meta_nxt.face = FACE_NONE;
		end
		meta_nxt.oor  = 1'b0;
		meta_nxt.last = seq_last;
		// An error result carries nothing but its two flags.
		if (err_q) begin
			meta_nxt      = '0;
			meta_nxt.oor  = 1'b1;
			meta_nxt.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= issue;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1 <= meta_nxt;
			if (err_q) begin
				px_s1 <= '0;
				py_s1 <= '0;
				pz_s1 <= '0;
			end else begin
				px_s1 <= {1'b0, cx_q} + {5'b00000, dx_q} - DIM_W'(1);
				py_s1 <= {1'b0, cy_q} + {5'b00000, dy_q} - DIM_W'(1);
				pz_s1 <= {1'b0, cz_q} + {5'b00000, dz_q} - DIM_W'(1);
			end
		end
	end

	// Stage 2: the two products of the flattened index.
	logic [DIM_W-1:0]   px_s2;
	logic [2*DIM_W-1:0] prod_y_s2;
	logic [IDX_W-1:0]   prod_z_s2;
	logic [3*DIM_W-1:0] prod_z_full;
	meta_t              meta_s2;

	assign prod_z_full = pz_s1 * nxy_q;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			px_s2     <= px_s1;
			prod_y_s2 <= py_s1 * nx;
			prod_z_s2 <= prod_z_full[IDX_W-1:0];
			meta_s2   <= meta_s1;
		end
	end

	// Stage 3: final sum into the output register.
	logic [IDX_W-1:0] idx_s3;
	meta_t            meta_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			idx_s3  <= IDX_W'(px_s2) + IDX_W'(prod_y_s2) + prod_z_s2;
			meta_s3 <= meta_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {4'b0000, meta_s3.face, meta_s3.in_half, meta_s3.is_self,
	                        meta_s3.slot, idx_s3};
	assign m_axis_tuser  = meta_s3.oor;
	assign m_axis_tlast  = meta_s3.last;

	`CNSG_ASSERT(a_err_is_last, clk, arst_n, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "error transfer not marked last")
	`CNSG_ASSERT_NEVER(a_err_fields_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser && (m_axis_tdata != '0), "error transfer with nonzero fields")
	`CNSG_ASSERT(a_self_tags, clk, arst_n, (m_axis_tvalid && m_axis_tdata[IDX_W+SLOT_W]) |-> (m_axis_tdata[IDX_W+SLOT_W-1:IDX_W] == SLOT_SELF && m_axis_tdata[IDX_W+SLOT_W+FACE_W+1:IDX_W+SLOT_W+2] == FACE_NONE), "self result with wrong slot or face")
	`CNSG_ASSERT_NEVER(a_no_accept_mid_run, clk, arst_n, busy_q && !seq_last && s_axis_tready, "input taken before the run ends")

endmodule
